FILE: src/calendar_date_stepper_macros.svh
// Assertion macros for the calendar date stepper.
// Used by calendar_date_stepper.sv; expects aclk and aresetn in scope.
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define CDS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("calendar_date_stepper: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define CDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("calendar_date_stepper: next-cycle check failed");

`else

`define CDS_ASSERT_NOW(lbl, ante, cons)
`define CDS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/cds_pkg.sv
// Package for the calendar date stepper: payload structs, operation codes,
// sequencer states, constants and the month length function. No dependencies.
`default_nettype none

package cds_pkg;

    // Field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 16;
    localparam int WDAY_W   = 17;  // working day count: day plus signed offset

    localparam int MAX_YEAR_DEF = 9999;

    // Leap test: y / 100 as (y * 5243) >> 19, exact for every 14-bit year
    localparam int CENTURY     = 100;
    localparam int RECIP_W     = 13;
    localparam int LEAP_RECIP  = 5243;
    localparam int LEAP_SHIFT  = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - LEAP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_NEXT = 2'd1,
        OP_PREV = 2'd2,
        OP_ADD  = 2'd3
    } cds_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEAP_MUL,
        ST_LEAP_CHK,
        ST_WALK,
        ST_CLAMP,
        ST_FIN
    } cds_state_t;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [DAY_W-1:0]           load_day;
        logic [MONTH_W-1:0]         load_month;
        logic [YEAR_W-1:0]          load_year;
        logic signed [OFFSET_W-1:0] day_offset;
    } cds_in_t;

    typedef struct packed {
        logic [DAY_W-1:0]   cur_day;
        logic [MONTH_W-1:0] cur_month;
        logic [YEAR_W-1:0]  cur_year;
        logic               is_leap;
        logic               range_error;
    } cds_out_t;

    // Days in a month; months that mean nothing read as 31
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: src/calendar_date_stepper.sv
// Gregorian date register with load, single-day steps and signed day offsets.
// Depends on cds_pkg and calendar_date_stepper_macros.svh.
//
//  channel | ports                      | direction | payload
//  --------+----------------------------+-----------+-----------------------------
//  input   | s_valid, s_ready, s_data   | in        | cds_in_t  (operation, load, offset)
//  result  | m_valid, m_ready, m_data   | out       | cds_out_t (date, leap, error)
//
// A load runs the leap unit and the day clamp; a bad year goes straight to the end.
// Steps and offsets walk one month per cycle in the shared add/compare unit,
// pausing in the leap unit for every year crossed.
// Reset sets the date to 1 January of year 1; no clearing pass.
// A new transaction is taken in idle even while a result waits; a finished
// operation holds in its final state until the result register is free.
`default_nettype none
`include "calendar_date_stepper_macros.svh"

module calendar_date_stepper
    import cds_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output      logic     s_ready,
    input  wire cds_in_t  s_data,
    output      logic     m_valid,
    input  wire logic     m_ready,
    output      cds_out_t m_data
);

    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);

    cds_state_t state_reg, state_next;

    // Committed date
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic               leap_reg, leap_next;

    // Working copy used by the walk
    logic signed [WDAY_W-1:0] wday_reg, wday_next;
    logic [MONTH_W-1:0]       wmonth_reg, wmonth_next;
    logic [YEAR_W-1:0]        wyear_reg, wyear_next;
    logic                     wleap_reg, wleap_next;
    logic                     fwd_reg, fwd_next;
    logic                     load_reg, load_next;
    logic                     err_reg, err_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;

    logic     m_valid_reg, m_valid_next;
    cds_out_t m_data_reg, m_data_next;

    // Shared add/compare unit
    logic [MONTH_W-1:0]       prev_month;
    logic [DAY_W-1:0]         len_fwd;
    logic [DAY_W-1:0]         len_sel;
    logic signed [WDAY_W-1:0] len_ext;
    logic signed [WDAY_W-1:0] walk_sum;
    logic                     need_step;

    // Leap unit second stage
    logic [QUOT_W-1:0] cent_q;
    logic [YEAR_W-1:0] cent_back;
    logic              leap_calc;

    // Input decode
    logic signed [WDAY_W-1:0] step_delta;
    logic [MONTH_W-1:0]       load_month_c;
    logic                     load_year_bad;
    logic [DAY_W-1:0]         clamp_day;
    logic                     fin_go;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign fin_go  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // Month length and one month step of the working day count
    always_comb begin
        prev_month = (wmonth_reg == MONTH_JAN) ? MONTH_DEC : wmonth_reg - 4'd1;
        len_fwd    = days_in(wmonth_reg, wleap_reg);
        len_sel    = fwd_reg ? len_fwd : days_in(prev_month, wleap_reg);
        len_ext    = $signed({{(WDAY_W-DAY_W){1'b0}}, len_sel});
        walk_sum   = fwd_reg ? (wday_reg - len_ext) : (wday_reg + len_ext);
        need_step  = fwd_reg ? (wday_reg > len_ext) : (wday_reg < $signed(WDAY_W'(1)));
    end

    // Leap test from the registered reciprocal product
    always_comb begin
        cent_q    = prod_reg[PROD_W-1:LEAP_SHIFT];
        cent_back = YEAR_W'(cent_q) * YEAR_W'(CENTURY);
        if (cent_back == wyear_reg) begin
            leap_calc = (cent_q[1:0] == 2'd0);
        end else begin
            leap_calc = (wyear_reg[1:0] == 2'd0);
        end
    end

    // Input decode and load clamps
    always_comb begin
        case (cds_op_t'(s_data.operation))
            OP_NEXT: step_delta = WDAY_W'(1);
            OP_PREV: step_delta = -WDAY_W'(1);
            default: step_delta = WDAY_W'($signed(s_data.day_offset));
        endcase
        if (s_data.load_month == 4'd0) begin
            load_month_c = MONTH_JAN;
        end else if (s_data.load_month > MONTH_DEC) begin
            load_month_c = MONTH_DEC;
        end else begin
            load_month_c = s_data.load_month;
        end
        load_year_bad = (s_data.load_year < YEAR_MIN) || (s_data.load_year > YEAR_MAX);
        if (wday_reg[DAY_W-1:0] == 5'd0) begin
            clamp_day = 5'd1;
        end else if (wday_reg[DAY_W-1:0] > len_fwd) begin
            clamp_day = len_fwd;
        end else begin
            clamp_day = wday_reg[DAY_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (cds_op_t'(s_data.operation) == OP_LOAD) begin
                        state_next = load_year_bad ? ST_FIN : ST_LEAP_MUL;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_LEAP_MUL: state_next = ST_LEAP_CHK;
            ST_LEAP_CHK: state_next = load_reg ? ST_CLAMP : ST_WALK;
            ST_WALK: begin
                if (!need_step) begin
                    state_next = ST_FIN;
                end else if (fwd_reg && wmonth_reg == MONTH_DEC) begin
                    state_next = (wyear_reg == YEAR_MAX) ? ST_FIN : ST_LEAP_MUL;
                end else if (!fwd_reg && wmonth_reg == MONTH_JAN) begin
                    state_next = (wyear_reg == YEAR_MIN) ? ST_FIN : ST_LEAP_MUL;
                end
            end
            ST_CLAMP: state_next = ST_FIN;
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        day_next     = day_reg;
        month_next   = month_reg;
        year_next    = year_reg;
        leap_next    = leap_reg;
        wday_next    = wday_reg;
        wmonth_next  = wmonth_reg;
        wyear_next   = wyear_reg;
        wleap_next   = wleap_reg;
        fwd_next     = fwd_reg;
        load_next    = load_reg;
        err_next     = err_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next    = 1'b0;
                    wmonth_next = month_reg;
                    wyear_next  = year_reg;
                    wleap_next  = leap_reg;
                    wday_next   = $signed({{(WDAY_W-DAY_W){1'b0}}, day_reg}) + step_delta;
                    fwd_next    = !step_delta[WDAY_W-1];
                    load_next   = (cds_op_t'(s_data.operation) == OP_LOAD);
                    if (cds_op_t'(s_data.operation) == OP_LOAD) begin
                        err_next    = load_year_bad;
                        wday_next   = $signed({{(WDAY_W-DAY_W){1'b0}}, s_data.load_day});
                        wmonth_next = load_month_c;
                        wyear_next  = s_data.load_year;
                    end
                end
            end
            ST_LEAP_MUL: begin
                prod_next = PROD_W'(wyear_reg) * PROD_W'(LEAP_RECIP);
            end
            ST_LEAP_CHK: begin
                wleap_next = leap_calc;
            end
            ST_WALK: begin
                if (need_step) begin
                    wday_next = walk_sum;
                    if (fwd_reg) begin
                        if (wmonth_reg == MONTH_DEC) begin
                            if (wyear_reg == YEAR_MAX) begin
                                err_next = 1'b1;
                            end else begin
                                wmonth_next = MONTH_JAN;
                                wyear_next  = wyear_reg + 14'd1;
                            end
                        end else begin
                            wmonth_next = wmonth_reg + 4'd1;
                        end
                    end else begin
                        if (wmonth_reg == MONTH_JAN) begin
                            if (wyear_reg == YEAR_MIN) begin
                                err_next = 1'b1;
                            end else begin
                                wmonth_next = MONTH_DEC;
                                wyear_next  = wyear_reg - 14'd1;
                            end
                        end else begin
                            wmonth_next = prev_month;
                        end
                    end
                end
            end
            ST_CLAMP: begin
                wday_next = $signed({{(WDAY_W-DAY_W){1'b0}}, clamp_day});
            end
            ST_FIN: begin
                if (fin_go) begin
                    m_valid_next = 1'b1;
                    if (err_reg) begin
                        m_data_next = '{cur_day: day_reg, cur_month: month_reg,
                                        cur_year: year_reg, is_leap: leap_reg,
                                        range_error: 1'b1};
                    end else begin
                        day_next    = wday_reg[DAY_W-1:0];
                        month_next  = wmonth_reg;
                        year_next   = wyear_reg;
                        leap_next   = wleap_reg;
                        m_data_next = '{cur_day: wday_reg[DAY_W-1:0], cur_month: wmonth_reg,
                                        cur_year: wyear_reg, is_leap: wleap_reg,
                                        range_error: 1'b0};
                    end
                end
            end
            default: begin
                err_next = 1'b0;
            end
        endcase
    end

    // Control and committed date registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            day_reg     <= 5'd1;
            month_reg   <= MONTH_JAN;
            year_reg    <= YEAR_MIN;
            leap_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            day_reg     <= day_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
            leap_reg    <= leap_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        wday_reg   <= wday_next;
        wmonth_reg <= wmonth_next;
        wyear_reg  <= wyear_next;
        wleap_reg  <= wleap_next;
        fwd_reg    <= fwd_next;
        load_reg   <= load_next;
        err_reg    <= err_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    // Checks
    `CDS_ASSERT_NOW(a_date_in_range, 1'b1, (month_reg >= MONTH_JAN && month_reg <= MONTH_DEC && year_reg >= YEAR_MIN && year_reg <= YEAR_MAX))
    `CDS_ASSERT_NOW(a_day_fits_month, 1'b1, (day_reg >= 5'd1 && day_reg <= days_in(month_reg, leap_reg)))
    `CDS_ASSERT_NOW(a_walk_year_in_range, (state_reg == ST_WALK), (wyear_reg >= YEAR_MIN && wyear_reg <= YEAR_MAX))
    `CDS_ASSERT_NEXT(a_error_keeps_date, (fin_go && err_reg), ($stable(day_reg) && $stable(month_reg) && $stable(year_reg) && $stable(leap_reg)))
    `CDS_ASSERT_NEXT(a_one_at_a_time, (s_valid && s_ready), !s_ready)

endmodule

`default_nettype wire

FILE: sim/calendar_date_stepper_tb.sv
// Self-checking testbench for calendar_date_stepper: directed and random date operations.
// Depends on cds_pkg and the RTL. An internal calendar predictor works out each expected
// result, and every result transaction is checked field by field against it.
module calendar_date_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cds_pkg::*;

    localparam int YEAR_LIMIT   = MAX_YEAR_DEF;
    localparam int CLK_HALF     = 10;
    localparam int IDLE_PCT     = 35;
    localparam int STALL_LIMIT  = 20000;   // well above the longest offset walk
    localparam int DRAIN_CYCLES = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cds_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cds_out_t m_data;

    bit       steady;          // no idling on either side while set
    int       err_count;
    int       quiet_cycles;
    cds_out_t date_q[$];       // dates still owed by the block, oldest first

    // Predicted calendar state, 1 January of year 1 after reset
    int cal_day   = 1;
    int cal_month = 1;
    int cal_year  = 1;

    calendar_date_stepper #(
        .MAX_YEAR(YEAR_LIMIT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(int m, int y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Walks whole months; returns 1 and leaves the date alone if the year leaves range
    function automatic bit shift_date(int off);
        int d;
        int m;
        int y;
        d = cal_day + off;
        m = cal_month;
        y = cal_year;
        if (off > 0) begin
            while (d > month_length(m, y)) begin
                d -= month_length(m, y);
                if (m == 12) begin
                    m = 1;
                    y++;
                    if (y > YEAR_LIMIT) return 1'b1;
                end else begin
                    m++;
                end
            end
        end else begin
            while (d < 1) begin
                if (m == 1) begin
                    m = 12;
                    y--;
                    if (y < 1) return 1'b1;
                end else begin
                    m--;
                end
                d += month_length(m, y);
            end
        end
        cal_day   = d;
        cal_month = m;
        cal_year  = y;
        return 1'b0;
    endfunction

    function automatic cds_out_t step_date(cds_in_t req);
        cds_out_t res;
        bit       bad;
        int       d;
        int       m;
        int       y;
        int       off;
        bad = 1'b0;
        case (cds_op_t'(req.operation))
            OP_LOAD: begin
                d = req.load_day;
                m = req.load_month;
                y = req.load_year;
                if (y < 1 || y > YEAR_LIMIT) begin
                    bad = 1'b1;
                end else begin
                    if (m < 1) m = 1;
                    if (m > 12) m = 12;
                    if (d < 1) d = 1;
                    if (d > month_length(m, y)) d = month_length(m, y);
                    cal_day   = d;
                    cal_month = m;
                    cal_year  = y;
                end
            end
            OP_NEXT: bad = shift_date(1);
            OP_PREV: bad = shift_date(-1);
            default: begin
                off = $signed(req.day_offset);
                if (off != 0) bad = shift_date(off);
            end
        endcase
        res.cur_day     = cal_day[DAY_W-1:0];
        res.cur_month   = cal_month[MONTH_W-1:0];
        res.cur_year    = cal_year[YEAR_W-1:0];
        res.is_leap     = leap_year(cal_year);
        res.range_error = bad;
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Predict on each accepted input, compare on each accepted result
    always @(posedge aclk) begin
        cds_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) date_q.push_back(step_date(s_data));
            if (m_valid && m_ready) begin
                if (date_q.size() == 0) begin
                    $error("result transaction with no expected date pending");
                    err_count++;
                end else begin
                    want = date_q.pop_front();
                    check_field("cur_day",     want.cur_day,     m_data.cur_day);
                    check_field("cur_month",   want.cur_month,   m_data.cur_month);
                    check_field("cur_year",    want.cur_year,    m_data.cur_year);
                    check_field("is_leap",     want.is_leap,     m_data.is_leap);
                    check_field("range_error", want.range_error, m_data.range_error);
                end
            end
        end
    end

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic cds_in_t make_item(cds_op_t op, int d, int m, int y, int off);
        cds_in_t req;
        req.operation  = op;
        req.load_day   = d[DAY_W-1:0];
        req.load_month = m[MONTH_W-1:0];
        req.load_year  = y[YEAR_W-1:0];
        req.day_offset = off[OFFSET_W-1:0];
        return req;
    endfunction

    // Called at a rising edge; returns at a rising edge after the transaction
    task automatic send_item(input cds_in_t req);
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
    endtask

    // Mostly short offsets; the long walks are kept rare
    function automatic int rand_offset();
        int          pick;
        logic [15:0] raw;
        pick = $urandom_range(99);
        raw  = 16'($urandom());
        if (pick < 70) return int'($urandom_range(800)) - 400;
        if (pick < 90) return int'($urandom_range(8000)) - 4000;
        return $signed(raw);
    endfunction

    // Years bunched at both ends of the range, some out of range altogether
    function automatic int rand_year();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) return $urandom_range(5, 1);
        if (pick < 40) return $urandom_range(YEAR_LIMIT, YEAR_LIMIT - 5);
        if (pick < 50) return $urandom_range(16383, 0);
        return $urandom_range(YEAR_LIMIT, 1);
    endfunction

    task automatic test_reset_state();
        // step back from 1 January of year 1
        send_item(make_item(OP_PREV, 0, 0, 0, 0));
    endtask

    task automatic test_load_clamping();
        send_item(make_item(OP_LOAD, 0, 0, 2000, 0));           // day and month zero
        send_item(make_item(OP_LOAD, 31, 15, 1900, 0));         // month above 12
        send_item(make_item(OP_LOAD, 31, 2, 2000, 0));          // leap by 400
        send_item(make_item(OP_LOAD, 30, 2, 1900, 0));          // century, not leap
        send_item(make_item(OP_LOAD, 31, 4, 2024, 0));          // 30-day month
        send_item(make_item(OP_LOAD, 15, 6, 0, 0));             // year zero
        send_item(make_item(OP_LOAD, 15, 6, 16383, 0));         // year above the limit
        send_item(make_item(OP_LOAD, 31, 12, YEAR_LIMIT, 0));   // last day of range
    endtask

    task automatic test_day_steps();
        send_item(make_item(OP_NEXT, 0, 0, 0, 0));              // overflow past the last year
        send_item(make_item(OP_PREV, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 28, 2, 2004, 0));
        send_item(make_item(OP_NEXT, 0, 0, 0, 0));
        send_item(make_item(OP_NEXT, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 1, 3, 2100, 0));
        send_item(make_item(OP_PREV, 0, 0, 0, 0));
    endtask

    task automatic test_offsets();
        send_item(make_item(OP_ADD, 0, 0, 0, 0));               // zero offset
        send_item(make_item(OP_LOAD, 1, 1, 1, 0));
        send_item(make_item(OP_ADD, 0, 0, 0, 32767));
        send_item(make_item(OP_ADD, 0, 0, 0, -32768));          // underflow
        send_item(make_item(OP_LOAD, 1, 1, 2, 0));
        send_item(make_item(OP_ADD, 0, 0, 0, -366));            // one day short of year 1
        send_item(make_item(OP_ADD, 0, 0, 0, -365));
        send_item(make_item(OP_LOAD, 1, 12, YEAR_LIMIT, 0));
        send_item(make_item(OP_ADD, 0, 0, 0, 31));              // overflow by one day
        send_item(make_item(OP_ADD, 0, 0, 0, 30));
    endtask

    // Load a date, then a short run of steps; some pure noise in between
    task automatic test_random_sequences(input int n_items);
        int          sent;
        int          run;
        int          d;
        int          m;
        logic [63:0] raw;
        cds_op_t     op;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                raw = {$urandom(), $urandom()};
                send_item(raw[$bits(cds_in_t)-1:0]);
                sent++;
            end else begin
                d = ($urandom_range(3) == 0) ? 31 : $urandom_range(31);
                m = ($urandom_range(4) == 0) ? 12 : $urandom_range(15);
                send_item(make_item(OP_LOAD, d, m, rand_year(), $urandom()));
                run = $urandom_range(10, 2);
                repeat (run) begin
                    case ($urandom_range(2))
                        0:       op = OP_NEXT;
                        1:       op = OP_PREV;
                        default: op = OP_ADD;
                    endcase
                    send_item(make_item(op, $urandom_range(31), $urandom_range(15),
                                        $urandom_range(16383), rand_offset()));
                end
                sent += run + 1;
            end
        end
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        test_random_sequences(60);
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_load_clamping();
        test_day_steps();
        test_offsets();
        test_back_to_back();
        test_random_sequences(340);
        s_valid <= 1'b0;

        // Let the checker log the last transaction, then drain the results
        @(posedge aclk);
        while (date_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/cds_pkg.sv
src/calendar_date_stepper.sv
sim/calendar_date_stepper_tb.sv
